// ----- src/hms_pkg.sv -----
package hms_pkg;

  // Axis count bounds and default
  localparam int AXES_DEFAULT = 6;
  localparam int AXES_MAX     = 8;

  // Field widths fixed by the interface
  localparam int OP_W       = 3;
  localparam int AXIS_IDX_W = 3;
  localparam int PHASE_W    = 3;
  localparam int ELAPSED_W  = 24;
  localparam int BACKOFF_W  = 16;
  localparam int PCT_W      = 7;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [ELAPSED_W-1:0] TIMEOUT_RST = 24'd1200000;
  localparam logic [BACKOFF_W-1:0] BACKOFF_RST = 16'd200;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Progress scaling: quarters * 25 / count, count done by reciprocal
  localparam int                 PCT_PER_QUARTER = 25;
  localparam logic [PCT_W-1:0]   PCT_FULL        = 7'd100;
  localparam int                 RECIP_FRAC      = 16;
  localparam int                 RECIP_W         = RECIP_FRAC + 1;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_AXIS_ENABLE    = 2'd0,
    REG_HOME_DIRECTION = 2'd1,
    REG_TIMEOUT_TICKS  = 2'd2,
    REG_BACKOFF_STEPS  = 2'd3
  } cfg_reg_e;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_START_ALL = 3'd1,
    OP_STOP      = 3'd2,
    OP_INIT      = 3'd3,
    OP_START_ONE = 3'd4
  } op_e;

  // Per-axis homing phase
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 3'd0,
    PH_FAST = 3'd1,
    PH_BACK = 3'd2,
    PH_SLOW = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5
  } phase_e;

  // Drive speed codes
  localparam logic [1:0] DRIVE_STOP = 2'd0;
  localparam logic [1:0] DRIVE_FAST = 2'd1;
  localparam logic [1:0] DRIVE_SLOW = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } seq_state_e;

  // One axis record in the state memory; all-zero is the reset value
  typedef struct packed {
    phase_e                phase;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [BACKOFF_W-1:0]  backoff;
  } axis_rec_t;

  // Per-axis result of one update
  typedef struct packed {
    logic [1:0]   mode;
    logic         rev;
    logic         zero;
    logic         done;
    logic         err;
    logic         active;
    logic         enabled;
    logic [2:0]   quarters;
    phase_e       phase;
  } axis_out_t;

  // ceil(2^16 / d) for d in 1..8; exact floor division for products up to 800
  function automatic logic [RECIP_W-1:0] recip_f(input logic [3:0] d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/multi_axis_homing_sequencer.sv -----
// Homing sequencer: per-axis records live in a small memory with a registered read port.
// Items are taken only in idle, so a new item waits until the last one has
// been emitted: each item walks the axes with one memory read/write per axis,
// then runs the two-stage progress divide; a result left waiting on out_ready_i
// holds off the next item for as long as it waits.
// Reset (rst_ni low, async): registers take their reset values, all axes read
// idle with zero counters, the sticky complete flag clears; no clearing pass.
module multi_axis_homing_sequencer #(
  parameter int AXES = hms_pkg::AXES_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hms_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hms_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hms_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [hms_pkg::OP_W-1:0]          operation_i,
  input  logic [hms_pkg::AXIS_IDX_W-1:0]    axis_i,
  input  logic [AXES-1:0]                   endstop_hits_i,
  input  logic [AXES-1:0]                   backoff_step_done_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2*AXES-1:0]                 drive_mode_o,
  output logic [AXES-1:0]                   drive_reverse_o,
  output logic [AXES-1:0]                   zero_position_o,
  output logic [AXES-1:0]                   done_mask_o,
  output logic [AXES-1:0]                   error_mask_o,
  output logic                              all_complete_o,
  output logic [hms_pkg::PCT_W-1:0]         progress_percent_o,
  output logic [3*AXES-1:0]                 axis_states_o
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int QW = $clog2(4 * AXES + 1);
  localparam int CW = $clog2(AXES + 1);
  localparam logic [AW-1:0] LAST_AXIS = AW'(AXES - 1);

  // Configuration registers
  logic [AXES-1:0]                   axis_enable_q;
  logic [AXES-1:0]                   home_direction_q;
  logic [hms_pkg::ELAPSED_W-1:0]     timeout_ticks_q;
  logic [hms_pkg::BACKOFF_W-1:0]     backoff_steps_q;
  logic                              cfg_we;
  hms_pkg::cfg_reg_e                 cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = hms_pkg::cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_enable_q    <= '1;
      home_direction_q <= '0;
      timeout_ticks_q  <= hms_pkg::TIMEOUT_RST;
      backoff_steps_q  <= hms_pkg::BACKOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        hms_pkg::REG_AXIS_ENABLE:    axis_enable_q    <= pwdata[AXES-1:0];
        hms_pkg::REG_HOME_DIRECTION: home_direction_q <= pwdata[AXES-1:0];
        hms_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_q  <= pwdata[hms_pkg::ELAPSED_W-1:0];
        hms_pkg::REG_BACKOFF_STEPS:  backoff_steps_q  <= pwdata[hms_pkg::BACKOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_sel)
      hms_pkg::REG_AXIS_ENABLE:    prdata = hms_pkg::CFG_DATA_W'(axis_enable_q);
      hms_pkg::REG_HOME_DIRECTION: prdata = hms_pkg::CFG_DATA_W'(home_direction_q);
      hms_pkg::REG_TIMEOUT_TICKS:  prdata = hms_pkg::CFG_DATA_W'(timeout_ticks_q);
      hms_pkg::REG_BACKOFF_STEPS:  prdata = hms_pkg::CFG_DATA_W'(backoff_steps_q);
      default:                     prdata = '0;
    endcase
  end

  // Sequencer state and item registers
  hms_pkg::seq_state_e            state_q, state_d;
  logic [AW-1:0]                  idx_q;
  logic [hms_pkg::OP_W-1:0]       op_q;
  logic [hms_pkg::AXIS_IDX_W-1:0] ax_q;
  logic [AXES-1:0]                hits_q;
  logic [AXES-1:0]                steps_q;
  logic [QW-1:0]                  quarters_q;
  logic [CW-1:0]                  count_q;
  logic                           active_q;
  logic                           flag_q;
  hms_pkg::axis_out_t             res_q [AXES];

  logic                           in_acc;
  logic                           walk;
  logic                           last_axis;
  logic                           emit_ok;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  hms_pkg::axis_rec_t             rd_data;
  hms_pkg::axis_rec_t             wr_data;
  hms_pkg::axis_out_t             axis_res;
  logic [hms_pkg::PCT_W-1:0]      pct;
  logic                           out_valid_q;

  assign last_axis = (idx_q == LAST_AXIS);
  assign emit_ok   = !out_valid_q || out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hms_pkg::ST_IDLE:   if (in_valid_i) state_d = hms_pkg::ST_WALK;
      hms_pkg::ST_WALK:   if (last_axis) state_d = hms_pkg::ST_SCALE;
      hms_pkg::ST_SCALE:  state_d = hms_pkg::ST_DIVIDE;
      hms_pkg::ST_DIVIDE: state_d = hms_pkg::ST_EMIT;
      hms_pkg::ST_EMIT:   if (emit_ok) state_d = hms_pkg::ST_IDLE;
      default:            state_d = hms_pkg::ST_IDLE;
    endcase
  end

  // State-decoded controls; reads run one axis ahead of the update
  always_comb begin
    in_ready_o = 1'b0;
    walk       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    unique case (state_q)
      hms_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_en      = in_valid_i;
      end
      hms_pkg::ST_WALK: begin
        walk    = 1'b1;
        rd_en   = !last_axis;
        rd_addr = idx_q + AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item capture, axis walk and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      quarters_q <= '0;
      count_q    <= '0;
      active_q   <= 1'b0;
      flag_q     <= 1'b0;
    end else if (in_acc) begin
      idx_q      <= '0;
      quarters_q <= '0;
      count_q    <= '0;
      active_q   <= 1'b0;
    end else if (walk) begin
      idx_q      <= idx_q + AW'(1);
      quarters_q <= quarters_q + QW'(axis_res.quarters);
      count_q    <= count_q + CW'(axis_res.enabled);
      active_q   <= active_q | axis_res.active;
      if (last_axis) begin
        if (op_q == hms_pkg::OP_TICK) begin
          if (!(active_q | axis_res.active)) flag_q <= 1'b1;
        end else if (op_q == hms_pkg::OP_START_ALL || op_q == hms_pkg::OP_INIT) begin
          flag_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      ax_q    <= axis_i;
      hits_q  <= endstop_hits_i;
      steps_q <= backoff_step_done_i;
    end
    if (walk) begin
      res_q[idx_q] <= axis_res;
    end
  end

  // Axis record memory
  hms_state_mem #(
    .AXES (AXES),
    .AW   (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (walk),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_data)
  );

  // Per-axis update
  hms_axis_logic u_axis (
    .rec_i           (rd_data),
    .op_i            (op_q),
    .target_i        (4'(ax_q) == 4'(idx_q)),
    .enabled_i       (axis_enable_q[idx_q]),
    .hit_i           (hits_q[idx_q]),
    .step_i          (steps_q[idx_q]),
    .home_pos_i      (home_direction_q[idx_q]),
    .timeout_i       (timeout_ticks_q),
    .backoff_steps_i (backoff_steps_q),
    .rec_o           (wr_data),
    .res_o           (axis_res)
  );

  // Progress percentage
  hms_progress #(
    .AXES (AXES),
    .QW   (QW),
    .CW   (CW)
  ) u_progress (
    .clk_i      (clk_i),
    .quarters_i (quarters_q),
    .count_i    (count_q),
    .pct_o      (pct)
  );

  // Output register
  logic [2*AXES-1:0] mode_d;
  logic [AXES-1:0]   rev_d, zero_d, done_d, err_d;
  logic [3*AXES-1:0] states_d;
  logic              load_out;

  assign load_out = (state_q == hms_pkg::ST_EMIT) && emit_ok;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      mode_d[2*i +: 2]   = res_q[i].mode;
      rev_d[i]           = res_q[i].rev;
      zero_d[i]          = res_q[i].zero;
      done_d[i]          = res_q[i].done;
      err_d[i]           = res_q[i].err;
      states_d[3*i +: 3] = res_q[i].phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      drive_mode_o       <= mode_d;
      drive_reverse_o    <= rev_d;
      zero_position_o    <= zero_d;
      done_mask_o        <= done_d;
      error_mask_o       <= err_d;
      all_complete_o     <= flag_q;
      progress_percent_o <= pct;
      axis_states_o      <= states_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/hms_state_mem.sv -----
module hms_state_mem #(
  parameter int AXES = hms_pkg::AXES_DEFAULT,
  parameter int AW   = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output hms_pkg::axis_rec_t  rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  hms_pkg::axis_rec_t  wr_data_i
);

  hms_pkg::axis_rec_t mem [AXES];
  hms_pkg::axis_rec_t rd_data_q;
  logic [AXES-1:0]    vld_q;
  logic               rd_vld_q;

  // Storage array, one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Written flags: an unwritten entry reads as the reset record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- src/hms_axis_logic.sv -----
module hms_axis_logic (
  input  hms_pkg::axis_rec_t                  rec_i,
  input  logic [hms_pkg::OP_W-1:0]            op_i,
  input  logic                                target_i,
  input  logic                                enabled_i,
  input  logic                                hit_i,
  input  logic                                step_i,
  input  logic                                home_pos_i,
  input  logic [hms_pkg::ELAPSED_W-1:0]       timeout_i,
  input  logic [hms_pkg::BACKOFF_W-1:0]       backoff_steps_i,
  output hms_pkg::axis_rec_t                  rec_o,
  output hms_pkg::axis_out_t                  res_o
);

  hms_pkg::axis_rec_t             nxt;
  logic [hms_pkg::ELAPSED_W-1:0]  el_inc;
  logic                           moving;
  logic                           active;
  logic                           zero;

  assign moving = (rec_i.phase == hms_pkg::PH_FAST) || (rec_i.phase == hms_pkg::PH_BACK) ||
                  (rec_i.phase == hms_pkg::PH_SLOW);
  assign el_inc = (rec_i.elapsed != hms_pkg::ELAPSED_MAX) ?
                  rec_i.elapsed + hms_pkg::ELAPSED_W'(1) : rec_i.elapsed;

  // Phase and counter update for this operation
  always_comb begin
    nxt    = rec_i;
    active = 1'b0;
    zero   = 1'b0;
    unique case (op_i)
      hms_pkg::OP_TICK: begin
        if (enabled_i && moving) begin
          nxt.elapsed = el_inc;
          if (el_inc > timeout_i) begin
            nxt.phase = hms_pkg::PH_ERR;
          end else begin
            active = 1'b1;
            unique case (rec_i.phase)
              hms_pkg::PH_FAST: begin
                if (hit_i) begin
                  nxt.phase   = hms_pkg::PH_BACK;
                  nxt.backoff = backoff_steps_i;
                end
              end
              hms_pkg::PH_BACK: begin
                if (rec_i.backoff == '0) begin
                  nxt.phase = hms_pkg::PH_SLOW;
                end else if (step_i) begin
                  nxt.backoff = rec_i.backoff - hms_pkg::BACKOFF_W'(1);
                end
              end
              hms_pkg::PH_SLOW: begin
                if (hit_i) begin
                  nxt.phase = hms_pkg::PH_DONE;
                  zero      = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      hms_pkg::OP_START_ALL: begin
        if (enabled_i) begin
          nxt.phase   = hms_pkg::PH_FAST;
          nxt.elapsed = '0;
        end else begin
          nxt.phase = hms_pkg::PH_DONE;
        end
      end
      hms_pkg::OP_STOP: begin
        nxt.phase = hms_pkg::PH_IDLE;
      end
      hms_pkg::OP_INIT: begin
        nxt.phase   = hms_pkg::PH_IDLE;
        nxt.elapsed = '0;
      end
      hms_pkg::OP_START_ONE: begin
        if (target_i && enabled_i) begin
          nxt.phase   = hms_pkg::PH_FAST;
          nxt.elapsed = '0;
        end
      end
      default: ;
    endcase
  end

  // Drive, status and progress contribution from the new phase
  always_comb begin
    res_o          = '0;
    res_o.phase    = nxt.phase;
    res_o.zero     = zero;
    res_o.active   = active;
    res_o.enabled  = enabled_i;
    unique case (nxt.phase)
      hms_pkg::PH_FAST: begin
        res_o.mode     = hms_pkg::DRIVE_FAST;
        res_o.rev      = !home_pos_i;
        res_o.quarters = 3'd1;
      end
      hms_pkg::PH_BACK: begin
        res_o.mode     = hms_pkg::DRIVE_FAST;
        res_o.rev      = home_pos_i;
        res_o.quarters = 3'd2;
      end
      hms_pkg::PH_SLOW: begin
        res_o.mode     = hms_pkg::DRIVE_SLOW;
        res_o.rev      = !home_pos_i;
        res_o.quarters = 3'd3;
      end
      hms_pkg::PH_DONE: begin
        res_o.mode     = hms_pkg::DRIVE_STOP;
        res_o.done     = 1'b1;
        res_o.quarters = 3'd4;
      end
      hms_pkg::PH_ERR: begin
        res_o.err = 1'b1;
      end
      default: ;
    endcase
    if (!enabled_i) begin
      res_o.quarters = '0;
    end
  end

  assign rec_o = nxt;

endmodule

// ----- src/hms_progress.sv -----
module hms_progress #(
  parameter int AXES = hms_pkg::AXES_DEFAULT,
  parameter int QW   = $clog2(4 * AXES + 1),
  parameter int CW   = $clog2(AXES + 1)
) (
  input  logic                       clk_i,
  input  logic [QW-1:0]              quarters_i,
  input  logic [CW-1:0]              count_i,
  output logic [hms_pkg::PCT_W-1:0]  pct_o
);

  localparam int PW = $clog2(hms_pkg::PCT_PER_QUARTER * 4 * AXES + 1);
  localparam int MW = PW + hms_pkg::RECIP_W;

  logic [PW-1:0]               prod_q;
  logic [CW-1:0]               cnt_q;
  logic [hms_pkg::RECIP_W-1:0] recip;
  logic [MW-1:0]               scaled;
  logic [hms_pkg::PCT_W-1:0]   pct_q;

  // Stage 1: quarters times 25
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(quarters_i * hms_pkg::PCT_PER_QUARTER);
    cnt_q  <= count_i;
  end

  // Stage 2: divide by the enabled count through its reciprocal
  assign recip  = hms_pkg::recip_f(4'(cnt_q));
  assign scaled = MW'(prod_q) * MW'(recip);

  always_ff @(posedge clk_i) begin
    pct_q <= (cnt_q == '0) ? hms_pkg::PCT_FULL :
             scaled[hms_pkg::RECIP_FRAC +: hms_pkg::PCT_W];
  end

  assign pct_o = pct_q;

endmodule
